### hw/rtl/ptcp_pkg.sv
package ptcp_pkg;

	typedef enum logic [2:0] {
		REG_INTERIOR = 3'd0,
		REG_VERT_A   = 3'd1,
		REG_VERT_B   = 3'd2,
		REG_VERT_C   = 3'd3,
		REG_EDGE_AB  = 3'd4,
		REG_EDGE_BC  = 3'd5,
		REG_EDGE_CA  = 3'd6
	} region_t;

	localparam int QUEUE_DEPTH = 4;

endpackage

### hw/rtl/ptcp_front.sv
// front part: edge dot products, cross products and region classification
// stage 1 differences, stage 2 products, stage 3 sums, stage 4 classify
module ptcp_front #(
	parameter int CB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 adv,
	input  logic signed [CB-1:0] qx, qy, ax, ay, bx, by, cx, cy,
	output logic                 out_valid,
	output logic signed [CB-1:0] p0x_s4, p0y_s4,
	output logic signed [CB:0]   dx_s4, dy_s4,
	output logic signed [CB-1:0] qx_s4, qy_s4,
	output logic [2*CB+1:0]      num_s4, len_s4,
	output logic signed [2*CB+1:0] bu_s4, bv_s4, bw_s4,
	output ptcp_pkg::region_t    region_s4
);
	localparam int DW = CB + 1;
	localparam int PW = 2 * CB + 2;
	localparam int SW = 2 * CB + 4;

	logic [3:0] vld_q;

	// stage 1: differences
	logic signed [DW-1:0] e_dx_s1 [3], e_dy_s1 [3], e_qx_s1 [3], e_qy_s1 [3];
	logic signed [DW-1:0] rx_s1 [3], ry_s1 [3];
	logic signed [CB-1:0] px_s1 [3], py_s1 [3], q_x_s1, q_y_s1;

	// stage 2: products
	logic signed [PW-1:0] mxx_s2 [3], myy_s2 [3], nxx_s2 [3], nyy_s2 [3];
	logic signed [PW-1:0] c1_s2 [3], c2_s2 [3];
	logic signed [CB-1:0] px_s2 [3], py_s2 [3], q_x_s2, q_y_s2;
	logic signed [DW-1:0] dxo_s2 [3], dyo_s2 [3];

	// stage 3: sums
	logic signed [SW-1:0] len_s3 [3], num_s3 [3];
	logic signed [PW-1:0] cr_s3 [3];
	logic signed [CB-1:0] px_s3 [3], py_s3 [3], q_x_s3, q_y_s3;
	logic signed [DW-1:0] dxo_s3 [3], dyo_s3 [3];

	logic signed [CB-1:0] vx [3], vy [3];
	assign vx[0] = ax; assign vx[1] = bx; assign vx[2] = cx;
	assign vy[0] = ay; assign vy[1] = by; assign vy[2] = cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e_dx_s1[i] <= DW'(vx[(i+1)%3]) - DW'(vx[i]);
				e_dy_s1[i] <= DW'(vy[(i+1)%3]) - DW'(vy[i]);
				e_qx_s1[i] <= DW'(qx) - DW'(vx[i]);
				e_qy_s1[i] <= DW'(qy) - DW'(vy[i]);
				rx_s1[i] <= DW'(vx[i]) - DW'(qx);
				ry_s1[i] <= DW'(vy[i]) - DW'(qy);
				px_s1[i] <= vx[i];
				py_s1[i] <= vy[i];
			end
			q_x_s1 <= qx;
			q_y_s1 <= qy;

			for (int i = 0; i < 3; i++) begin
				mxx_s2[i] <= PW'(e_dx_s1[i]) * PW'(e_dx_s1[i]);
				myy_s2[i] <= PW'(e_dy_s1[i]) * PW'(e_dy_s1[i]);
				nxx_s2[i] <= PW'(e_qx_s1[i]) * PW'(e_dx_s1[i]);
				nyy_s2[i] <= PW'(e_qy_s1[i]) * PW'(e_dy_s1[i]);
				// cross of r[i+1] and r[i+2]
				c1_s2[i] <= PW'(rx_s1[(i+1)%3]) * PW'(ry_s1[(i+2)%3]);
				c2_s2[i] <= PW'(ry_s1[(i+1)%3]) * PW'(rx_s1[(i+2)%3]);
				px_s2[i] <= px_s1[i];
				py_s2[i] <= py_s1[i];
				dxo_s2[i] <= e_dx_s1[i];
				dyo_s2[i] <= e_dy_s1[i];
			end
			q_x_s2 <= q_x_s1;
			q_y_s2 <= q_y_s1;

			for (int i = 0; i < 3; i++) begin
				len_s3[i] <= SW'(mxx_s2[i]) + SW'(myy_s2[i]);
				num_s3[i] <= SW'(nxx_s2[i]) + SW'(nyy_s2[i]);
				cr_s3[i] <= c1_s2[i] - c2_s2[i];
				px_s3[i] <= px_s2[i];
				py_s3[i] <= py_s2[i];
				dxo_s3[i] <= dxo_s2[i];
				dyo_s3[i] <= dyo_s2[i];
			end
			q_x_s3 <= q_x_s2;
			q_y_s3 <= q_y_s2;
		end
	end

	// classification
	logic vn [3], un [3], on [3];
	ptcp_pkg::region_t reg_c;
	logic [1:0] sel_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vn[i] = (len_s3[i] != '0) && (num_s3[i] < 0);
			un[i] = (len_s3[i] != '0) && (num_s3[i] > len_s3[i]);
			on[i] = (len_s3[i] != '0) && (num_s3[i] > 0) && (num_s3[i] < len_s3[i]);
		end
		reg_c = ptcp_pkg::REG_INTERIOR;
		sel_c = 2'd0;
		if (un[2] && vn[0]) reg_c = ptcp_pkg::REG_VERT_A;
		else if (un[0] && vn[1]) reg_c = ptcp_pkg::REG_VERT_B;
		else if (un[1] && vn[2]) reg_c = ptcp_pkg::REG_VERT_C;
		else if (on[0] && cr_s3[2] <= 0) begin
			reg_c = ptcp_pkg::REG_EDGE_AB; sel_c = 2'd0;
		end else if (on[1] && cr_s3[0] <= 0) begin
			reg_c = ptcp_pkg::REG_EDGE_BC; sel_c = 2'd1;
		end else if (on[2] && cr_s3[1] <= 0) begin
			reg_c = ptcp_pkg::REG_EDGE_CA; sel_c = 2'd2;
		end
		unique case (reg_c)
			ptcp_pkg::REG_VERT_B: sel_c = 2'd1;
			ptcp_pkg::REG_VERT_C: sel_c = 2'd2;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0x_s4 <= px_s3[sel_c];
			p0y_s4 <= py_s3[sel_c];
			dx_s4 <= dxo_s3[sel_c];
			dy_s4 <= dyo_s3[sel_c];
			num_s4 <= PW'(num_s3[sel_c]);
			len_s4 <= PW'(len_s3[sel_c]);
			qx_s4 <= q_x_s3;
			qy_s4 <= q_y_s3;
			bu_s4 <= cr_s3[0];
			bv_s4 <= cr_s3[1];
			bw_s4 <= cr_s3[2];
			region_s4 <= reg_c;
		end
	end

	assign out_valid = vld_q[3];
endmodule

### hw/rtl/ptcp_back.sv
// back part: edge point by pipelined restoring division, one quotient digit a stage
module ptcp_back #(
	parameter int CB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   adv,
	input  logic signed [CB-1:0]   p0x, p0y,
	input  logic signed [CB:0]     dx, dy,
	input  logic signed [CB-1:0]   qx, qy,
	input  logic [2*CB+1:0]        num, len,
	input  logic signed [2*CB+1:0] bu, bv, bw,
	input  ptcp_pkg::region_t      region_in,
	output logic                   out_valid,
	output logic signed [CB-1:0]   near_x, near_y,
	output logic signed [2*CB+1:0] bary_u, bary_v, bary_w,
	output ptcp_pkg::region_t      region
);
	localparam int PW = 2 * CB + 2;
	localparam int RW = PW + 1;
	localparam int MW = CB + 1;
	localparam int NS = MW;

	typedef struct packed {
		logic [MW-1:0]          mx, my;
		logic                   sx, sy;
		logic [RW-1:0]          rx, ry;
		logic [MW-1:0]          qtx, qty;
		logic [PW-1:0]          n, l;
		logic signed [CB-1:0]   p0x, p0y, qx, qy;
		logic signed [PW-1:0]   bu, bv, bw;
		ptcp_pkg::region_t      rg;
	} stg_t;

	logic vld_q [NS+1];
	stg_t st_q [NS+1];
	stg_t nx_c [NS+1];

	// r < len and num < len give 2r+num < 3*len, so a stage digit is 0, 1 or 2
	always_comb begin
		logic [RW-1:0] tx, ty, l1, l2;
		nx_c[0].sx = dx[CB];
		nx_c[0].sy = dy[CB];
		nx_c[0].mx = dx[CB] ? MW'(-dx) : MW'(dx);
		nx_c[0].my = dy[CB] ? MW'(-dy) : MW'(dy);
		nx_c[0].rx = '0;
		nx_c[0].ry = '0;
		nx_c[0].qtx = '0;
		nx_c[0].qty = '0;
		nx_c[0].n = num;
		nx_c[0].l = len;
		nx_c[0].p0x = p0x;
		nx_c[0].p0y = p0y;
		nx_c[0].qx = qx;
		nx_c[0].qy = qy;
		nx_c[0].bu = bu;
		nx_c[0].bv = bv;
		nx_c[0].bw = bw;
		nx_c[0].rg = region_in;
		for (int k = 0; k < NS; k++) begin
			nx_c[k+1] = st_q[k];
			l1 = RW'(st_q[k].l);
			l2 = {l1[RW-2:0], 1'b0};
			tx = {st_q[k].rx[RW-2:0], 1'b0} +
				(st_q[k].mx[MW-1-k] ? RW'(st_q[k].n) : RW'(0));
			ty = {st_q[k].ry[RW-2:0], 1'b0} +
				(st_q[k].my[MW-1-k] ? RW'(st_q[k].n) : RW'(0));
			if (tx >= l2) begin
				nx_c[k+1].rx = tx - l2;
				nx_c[k+1].qtx = {st_q[k].qtx[MW-2:0], 1'b0} + MW'(2);
			end else if (tx >= l1) begin
				nx_c[k+1].rx = tx - l1;
				nx_c[k+1].qtx = {st_q[k].qtx[MW-2:0], 1'b1};
			end else begin
				nx_c[k+1].rx = tx;
				nx_c[k+1].qtx = {st_q[k].qtx[MW-2:0], 1'b0};
			end
			if (ty >= l2) begin
				nx_c[k+1].ry = ty - l2;
				nx_c[k+1].qty = {st_q[k].qty[MW-2:0], 1'b0} + MW'(2);
			end else if (ty >= l1) begin
				nx_c[k+1].ry = ty - l1;
				nx_c[k+1].qty = {st_q[k].qty[MW-2:0], 1'b1};
			end else begin
				nx_c[k+1].ry = ty;
				nx_c[k+1].qty = {st_q[k].qty[MW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k <= NS; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= NS; k++) st_q[k] <= nx_c[k];
		end
	end

	// rounding, sign and final select
	always_comb begin
		stg_t f;
		logic [MW-1:0] rqx, rqy;
		f = st_q[NS];
		rqx = f.qtx + MW'({f.rx, 1'b0} >= (RW+1)'(f.l));
		rqy = f.qty + MW'({f.ry, 1'b0} >= (RW+1)'(f.l));
		out_valid = vld_q[NS];
		bary_u = f.bu;
		bary_v = f.bv;
		bary_w = f.bw;
		region = f.rg;
		near_x = f.qx;
		near_y = f.qy;
		case (f.rg) inside
			ptcp_pkg::REG_VERT_A, ptcp_pkg::REG_VERT_B, ptcp_pkg::REG_VERT_C: begin
				near_x = f.p0x;
				near_y = f.p0y;
			end
			ptcp_pkg::REG_EDGE_AB, ptcp_pkg::REG_EDGE_BC, ptcp_pkg::REG_EDGE_CA: begin
				near_x = f.p0x + (f.sx ? CB'(-rqx) : CB'(rqx));
				near_y = f.p0y + (f.sy ? CB'(-rqy) : CB'(rqy));
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/ptcp_queue.sv
// small fifo of QUEUE_DEPTH entries, used between front and back and between back and output
module ptcp_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	output logic         nonempty,
	input  logic         pop,
	output logic [W-1:0] rdata
);
	localparam int D = ptcp_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(D);
	logic [W-1:0] mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
	assign rdata = mem_q[rp_q];
	assign full = cnt_q == (AW+1)'(D);
	assign nonempty = cnt_q != '0;
endmodule

### hw/rtl/point_triangle_closest_point_top.sv
// path from input transfer to output transfer: 4 front stages, the front queue,
// COORD_BITS+2 back stages and the output queue, plus queueing when stalled
// throughput: one transfer per cycle; each part freezes only when the queue after it fills
// reset: arst_n clears all valid flags and queue pointers, payload is not reset
module point_triangle_closest_point_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_BITS-1:0]   query_x, query_y,
	input  logic signed [COORD_BITS-1:0]   vert_a_x, vert_a_y,
	input  logic signed [COORD_BITS-1:0]   vert_b_x, vert_b_y,
	input  logic signed [COORD_BITS-1:0]   vert_c_x, vert_c_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [COORD_BITS-1:0]   near_x, near_y,
	output logic signed [2*COORD_BITS+1:0] bary_u, bary_v, bary_w,
	output logic [2:0]                     region
);
	localparam int CB = COORD_BITS;
	localparam int PW = 2 * CB + 2;
	localparam int QW = 6 * CB + 5 * PW + 5;
	localparam int OW = 2 * CB + 3 * PW + 3;

	logic f_adv, f_vld;
	logic signed [CB-1:0] p0x, p0y, qx, qy;
	logic signed [CB:0] dx, dy;
	logic [PW-1:0] num, len;
	logic signed [PW-1:0] bu, bv, bw;
	ptcp_pkg::region_t rg;

	ptcp_front #(.CB(CB)) u_front (
		.clk, .arst_n, .in_valid, .adv(f_adv),
		.qx(query_x), .qy(query_y), .ax(vert_a_x), .ay(vert_a_y),
		.bx(vert_b_x), .by(vert_b_y), .cx(vert_c_x), .cy(vert_c_y),
		.out_valid(f_vld), .p0x_s4(p0x), .p0y_s4(p0y), .dx_s4(dx), .dy_s4(dy),
		.qx_s4(qx), .qy_s4(qy), .num_s4(num), .len_s4(len),
		.bu_s4(bu), .bv_s4(bv), .bw_s4(bw), .region_s4(rg)
	);

	// queue 1: front to back, holds what the front has when back is stalled
	logic q1_full, q1_ne, q1_pop;
	logic [QW-1:0] q1_rd;
	logic q1_push;
	// front stalls only when its last stage holds an item the queue cannot take
	assign q1_push = f_vld && f_adv;
	logic q2_room;

	// front advance: stage 4 moves into the queue when it is not full
	assign f_adv = !q1_full || !f_vld;
	assign in_stall = !f_adv;

	ptcp_queue #(.W(QW)) u_q1 (
		.clk, .arst_n, .push(q1_push),
		.wdata({p0x, p0y, dx, dy, qx, qy, num, len, bu, bv, bw, rg}),
		.full(q1_full), .nonempty(q1_ne), .pop(q1_pop), .rdata(q1_rd)
	);

	logic b_adv, b_vld;
	logic signed [CB-1:0] nx, ny;
	logic signed [PW-1:0] ou, ov, ow;
	ptcp_pkg::region_t org;
	logic [2:0] q1_rg;
	assign q1_rg = q1_rd[2:0];

	assign q1_pop = q1_ne && b_adv;

	ptcp_back #(.CB(CB)) u_back (
		.clk, .arst_n, .in_valid(q1_ne), .adv(b_adv),
		.p0x(q1_rd[QW-1 -: CB]), .p0y(q1_rd[QW-CB-1 -: CB]),
		.dx(q1_rd[QW-2*CB-1 -: CB+1]), .dy(q1_rd[QW-3*CB-2 -: CB+1]),
		.qx(q1_rd[QW-4*CB-3 -: CB]), .qy(q1_rd[QW-5*CB-3 -: CB]),
		.num(q1_rd[QW-6*CB-3 -: PW]), .len(q1_rd[QW-6*CB-PW-3 -: PW]),
		.bu(q1_rd[QW-6*CB-2*PW-3 -: PW]), .bv(q1_rd[QW-6*CB-3*PW-3 -: PW]),
		.bw(q1_rd[QW-6*CB-4*PW-3 -: PW]), .region_in(ptcp_pkg::region_t'(q1_rg)),
		.out_valid(b_vld), .near_x(nx), .near_y(ny),
		.bary_u(ou), .bary_v(ov), .bary_w(ow), .region(org)
	);

	// queue 2: back to output, lets the back part run on while the output is stalled
	logic q2_full, q2_ne;
	logic [OW-1:0] q2_rd;
	assign q2_room = !q2_full;
	assign b_adv = q2_room || !b_vld;

	ptcp_queue #(.W(OW)) u_q2 (
		.clk, .arst_n, .push(b_vld && q2_room),
		.wdata({nx, ny, ou, ov, ow, 3'(org)}),
		.full(q2_full), .nonempty(q2_ne), .pop(q2_ne && !out_stall), .rdata(q2_rd)
	);

	assign out_valid = q2_ne;
	assign {near_x, near_y, bary_u, bary_v, bary_w, region} = q2_rd;
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int  CW = 16;
	localparam int  BW = 2 * CW + 2;
	localparam int  RANDOM_ITEMS = 1800;
	localparam int  TAIL_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [CW-1:0] qx, qy, ax, ay, bx, by, cx, cy;
	} tri_query_t;

	typedef struct {
		logic signed [CW-1:0] nx, ny;
		logic signed [BW-1:0] bu, bv, bw;
		ptcp_pkg::region_t    reg_code;
	} closest_t;

	typedef struct {
		longint num, len2, px, py;
	} edge_proj_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [CW-1:0] query_x, query_y, vert_a_x, vert_a_y;
	logic signed [CW-1:0] vert_b_x, vert_b_y, vert_c_x, vert_c_y;
	logic out_valid;
	logic out_stall;
	logic signed [CW-1:0] near_x, near_y;
	logic signed [BW-1:0] bary_u, bary_v, bary_w;
	logic [2:0] region;

	closest_t expected_q[$];
	int       n_errors = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	int       region_hits[7];
	longint   cycle_cnt = 0;
	bit       in_idle_on = 0;
	bit       out_stall_on = 0;
	int       hold_request = 0;
	int       hold_left = 0;

	point_triangle_closest_point_top #(.COORD_BITS(CW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.query_x(query_x), .query_y(query_y),
		.vert_a_x(vert_a_x), .vert_a_y(vert_a_y),
		.vert_b_x(vert_b_x), .vert_b_y(vert_b_y),
		.vert_c_x(vert_c_x), .vert_c_y(vert_c_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.near_x(near_x), .near_y(near_y),
		.bary_u(bary_u), .bary_v(bary_v), .bary_w(bary_w),
		.region(region)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rounds d*num/len2 to nearest, ties away from zero
	function automatic longint scale_to_edge(longint d, longint num, longint len2);
		longint mag, prod, q;
		mag = (d < 0) ? -d : d;
		prod = mag * num;
		q = prod / len2;
		if (2 * (prod % len2) >= len2)
			q++;
		return (d < 0) ? -q : q;
	endfunction

	function automatic edge_proj_t project_edge(longint qx, longint qy, longint x0,
			longint y0, longint x1, longint y1);
		edge_proj_t e;
		longint dx, dy;
		dx = x1 - x0;
		dy = y1 - y0;
		e.len2 = dx * dx + dy * dy;
		e.num = (qx - x0) * dx + (qy - y0) * dy;
		e.px = x0;
		e.py = y0;
		if (e.len2 > 0 && e.num > 0 && e.num < e.len2) begin
			e.px = x0 + scale_to_edge(dx, e.num, e.len2);
			e.py = y0 + scale_to_edge(dy, e.num, e.len2);
		end
		return e;
	endfunction

	function automatic closest_t predict_closest(tri_query_t t);
		closest_t   r;
		edge_proj_t ab, bc, ca;
		longint qx, qy, ax, ay, bx, by, cx, cy, bu, bv, bw, nx, ny;
		bit vn_ab, vn_bc, vn_ca, un_ab, un_bc, un_ca, on_ab, on_bc, on_ca;
		qx = t.qx; qy = t.qy; ax = t.ax; ay = t.ay;
		bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
		ab = project_edge(qx, qy, ax, ay, bx, by);
		bc = project_edge(qx, qy, bx, by, cx, cy);
		ca = project_edge(qx, qy, cx, cy, ax, ay);
		bu = (bx - qx) * (cy - qy) - (by - qy) * (cx - qx);
		bv = (cx - qx) * (ay - qy) - (cy - qy) * (ax - qx);
		bw = (ax - qx) * (by - qy) - (ay - qy) * (bx - qx);
		// a zero-length edge passes none of its sign tests
		vn_ab = ab.len2 > 0 && ab.num < 0;
		vn_bc = bc.len2 > 0 && bc.num < 0;
		vn_ca = ca.len2 > 0 && ca.num < 0;
		un_ab = ab.len2 > 0 && ab.num > ab.len2;
		un_bc = bc.len2 > 0 && bc.num > bc.len2;
		un_ca = ca.len2 > 0 && ca.num > ca.len2;
		on_ab = ab.len2 > 0 && ab.num > 0 && ab.num < ab.len2;
		on_bc = bc.len2 > 0 && bc.num > 0 && bc.num < bc.len2;
		on_ca = ca.len2 > 0 && ca.num > 0 && ca.num < ca.len2;
		nx = qx;
		ny = qy;
		r.reg_code = ptcp_pkg::REG_INTERIOR;
		if (un_ca && vn_ab) begin
			nx = ax; ny = ay; r.reg_code = ptcp_pkg::REG_VERT_A;
		end else if (un_ab && vn_bc) begin
			nx = bx; ny = by; r.reg_code = ptcp_pkg::REG_VERT_B;
		end else if (un_bc && vn_ca) begin
			nx = cx; ny = cy; r.reg_code = ptcp_pkg::REG_VERT_C;
		end else if (on_ab && bw <= 0) begin
			nx = ab.px; ny = ab.py; r.reg_code = ptcp_pkg::REG_EDGE_AB;
		end else if (on_bc && bu <= 0) begin
			nx = bc.px; ny = bc.py; r.reg_code = ptcp_pkg::REG_EDGE_BC;
		end else if (on_ca && bv <= 0) begin
			nx = ca.px; ny = ca.py; r.reg_code = ptcp_pkg::REG_EDGE_CA;
		end
		r.nx = nx[CW-1:0];
		r.ny = ny[CW-1:0];
		r.bu = bu[BW-1:0];
		r.bv = bv[BW-1:0];
		r.bw = bw[BW-1:0];
		return r;
	endfunction

	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	task automatic send_query(tri_query_t t);
		int gap;
		in_valid <= 1'b1;
		query_x <= t.qx; query_y <= t.qy;
		vert_a_x <= t.ax; vert_a_y <= t.ay;
		vert_b_x <= t.bx; vert_b_y <= t.by;
		vert_c_x <= t.cx; vert_c_y <= t.cy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(predict_closest(t));
		n_sent++;
		gap = in_idle_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (expected_q.size() > 0)
			@(posedge clk);
	endtask

	function automatic tri_query_t make_query(int qx, int qy, int ax, int ay,
			int bx, int by, int cx, int cy);
		tri_query_t t;
		t.qx = CW'(qx); t.qy = CW'(qy); t.ax = CW'(ax); t.ay = CW'(ay);
		t.bx = CW'(bx); t.by = CW'(by); t.cx = CW'(cx); t.cy = CW'(cy);
		return t;
	endfunction

	function automatic logic signed [CW-1:0] near_coord(int span);
		return CW'($urandom_range(0, 2 * span) - span);
	endfunction

	// mostly small triangles with the query nearby so every region is reached
	function automatic tri_query_t random_query();
		tri_query_t t;
		int kind, span;
		kind = $urandom_range(0, 99);
		span = ($urandom_range(0, 3) == 0) ? 30 : 2000;
		t.ax = near_coord(span); t.ay = near_coord(span);
		t.bx = near_coord(span); t.by = near_coord(span);
		t.cx = near_coord(span); t.cy = near_coord(span);
		t.qx = near_coord(span + span / 2); t.qy = near_coord(span + span / 2);
		if (kind < 15) begin
			{t.qx, t.qy, t.ax, t.ay} = {$urandom, $urandom};
			{t.bx, t.by, t.cx, t.cy} = {$urandom, $urandom};
		end else if (kind < 22) begin
			case ($urandom_range(0, 2))
				0: begin t.bx = t.ax; t.by = t.ay; end
				1: begin t.cx = t.bx; t.cy = t.by; end
				default: begin t.ax = t.cx; t.ay = t.cy; end
			endcase
		end else if (kind < 26) begin
			// collinear vertices
			t.cx = CW'(t.ax + 2 * (t.bx - t.ax));
			t.cy = CW'(t.ay + 2 * (t.by - t.ay));
		end else if (kind < 30) begin
			// query on a vertex
			t.qx = t.bx; t.qy = t.by;
		end
		return t;
	endfunction

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= out_stall_on && ($urandom_range(0, 99) < 30);
		end
	end

	always @(posedge clk) begin
		closest_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transfer, near=(%0d,%0d) region=%0d",
					$time, near_x, near_y, region);
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				n_checked++;
				region_hits[e.reg_code]++;
				if (near_x !== e.nx) begin
					$display("%0t: near_x expected %0d actual %0d", $time, e.nx, near_x);
					n_errors++;
				end
				if (near_y !== e.ny) begin
					$display("%0t: near_y expected %0d actual %0d", $time, e.ny, near_y);
					n_errors++;
				end
				if (bary_u !== e.bu) begin
					$display("%0t: bary_u expected %0d actual %0d", $time, e.bu, bary_u);
					n_errors++;
				end
				if (bary_v !== e.bv) begin
					$display("%0t: bary_v expected %0d actual %0d", $time, e.bv, bary_v);
					n_errors++;
				end
				if (bary_w !== e.bw) begin
					$display("%0t: bary_w expected %0d actual %0d", $time, e.bw, bary_w);
					n_errors++;
				end
				if (region !== e.reg_code) begin
					$display("%0t: region expected %0d actual %0d", $time, e.reg_code,
						region);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_regions();
		// right triangle A(0,0) B(160,0) C(0,160) in Q12.4, legs of 10.0
		send_query(make_query(40, 40, 0, 0, 160, 0, 0, 160));
		send_query(make_query(-30, -20, 0, 0, 160, 0, 0, 160));
		send_query(make_query(200, -10, 0, 0, 160, 0, 0, 160));
		send_query(make_query(-5, 220, 0, 0, 160, 0, 0, 160));
		send_query(make_query(77, -33, 0, 0, 160, 0, 0, 160));
		send_query(make_query(120, 121, 0, 0, 160, 0, 0, 160));
		send_query(make_query(-41, 63, 0, 0, 160, 0, 0, 160));
		// edge point at the midpoint of AB, once as given and once mirrored through the origin
		send_query(make_query(1, -5, 0, 0, 2, 0, 0, 9));
		send_query(make_query(-1, 5, 0, 0, -2, 0, 0, -9));
	endtask

	task automatic test_degenerate();
		send_query(make_query(10, 10, 5, 5, 5, 5, 40, -7));
		send_query(make_query(-9, 3, 5, 5, 30, 2, 30, 2));
		send_query(make_query(7, 7, 8, 1, 8, 1, 8, 1));
		send_query(make_query(8, 1, 8, 1, 8, 1, 8, 1));
		send_query(make_query(3, 50, 0, 0, 10, 10, 20, 20));
	endtask

	task automatic test_extremes();
		send_query(make_query(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_query(make_query(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
		send_query(make_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
		send_query(make_query(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
		send_query(make_query(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
		send_query(make_query(-1, -1, -1, 0, 0, -1, 0, 0));
	endtask

	task automatic test_backpressure();
		in_idle_on = 0;
		hold_request = 300;
		repeat (80) send_query(random_query());
		// sender pauses until the pipeline has emptied
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
	endtask

	task automatic test_random();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate stretches with and without input idling and output stalls
			if (i % 300 == 0) begin
				in_idle_on = (i % 600) != 0;
				out_stall_on = (i % 900) != 0;
			end
			send_query(random_query());
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{query_x, query_y, vert_a_x, vert_a_y} = '0;
		{vert_b_x, vert_b_y, vert_c_x, vert_c_y} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_idle_on = 1;
		out_stall_on = 1;
		test_regions();
		test_degenerate();
		test_extremes();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d queries, checked %0d results", n_sent, n_checked);
		$display("region counts: in %0d, A %0d, B %0d, C %0d, AB %0d, BC %0d, CA %0d",
			region_hits[0], region_hits[1], region_hits[2], region_hits[3],
			region_hits[4], region_hits[5], region_hits[6]);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
